[hw/rtl/hcdc_pkg.sv]
// Shared constants, types and register codes for the HSV colour defect classifier.
`default_nettype none

package hcdc_pkg;

    // Sizing of the row counter and the pixel counters.
    localparam int MAX_ROWS   = 1024;
    localparam int COUNT_BITS = 20;
    localparam int ROW_W      = $clog2(MAX_ROWS + 1);

    // Fixed field and register widths.
    localparam int PIX_W      = 8;
    localparam int BOX_W      = 48;
    localparam int THR_W      = 20;
    localparam int TOTAL_W    = 20;
    localparam int CFG_ROW_W  = 11;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Common widths for comparisons between counters and register values.
    localparam int WIN_W = (ROW_W > CFG_ROW_W) ? ROW_W : CFG_ROW_W;
    localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

    // Reciprocal tables used by the HSV conversion, 12 fractional bits.
    localparam int TAB_DEPTH = 1 << PIX_W;
    localparam int S_NUM     = 255 * 4096;
    localparam int H_NUM     = 180 * 4096;
    localparam int RECIP_S_W = 20;
    localparam int RECIP_H_W = 17;

    // Queue between the front and back parts, and the result queue.
    localparam int MQ_DEPTH   = 8;
    localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W   = $clog2(MQ_DEPTH + 1);
    localparam int RES_DEPTH  = 2;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    localparam logic [CFG_ROW_W-1:0] STOP_ROW_RESET = CFG_ROW_W'(1024);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_BOX_A      = 3'd0,
        CFG_RED_BOX_B      = 3'd1,
        CFG_BLUE_BOX       = 3'd2,
        CFG_RED_THRESHOLD  = 3'd3,
        CFG_BLUE_THRESHOLD = 3'd4,
        CFG_FIRST_ROW      = 3'd5,
        CFG_STOP_ROW       = 3'd6
    } cfg_index_t;

    // Frame classification codes.
    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_RED  = 2'd1,
        CLASS_BLUE = 2'd2
    } defect_class_t;

    // Per-pixel outcome handed from the front part to the back part.
    typedef struct packed {
        logic red_hit;
        logic blue_hit;
        logic frame_end;
    } pix_flags_t;

    // One frame result.
    typedef struct packed {
        defect_class_t          cls;
        logic [TOTAL_W-1:0]     red_total;
        logic [TOTAL_W-1:0]     blue_total;
    } result_t;

    // Settings the front part needs.
    typedef struct packed {
        logic [BOX_W-1:0]     red_box_a;
        logic [BOX_W-1:0]     red_box_b;
        logic [BOX_W-1:0]     blue_box;
        logic [CFG_ROW_W-1:0] first_row;
        logic [CFG_ROW_W-1:0] stop_row;
    } front_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/hsv_colour_defect_classifier_top.sv]
// Top level of the HSV colour defect classifier.
//
// Pixels enter through a queue-like port: a beat is taken when push is high
// and full is low. Each beat carries one BGR pixel with its end-of-row and
// end-of-frame marks. Results leave through a second queue-like port: while
// empty is low a frame result is on defect_class, red_total and blue_total,
// and pop takes it. One result appears for each frame-end pixel.
// Throughput is one pixel per clock while full is low, set by the
// four-stage HSV pipeline of the front part. A frame result is visible
// once its frame-end beat has passed the inner queue into the result queue.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect
// at the next edge and must only be made while no pixel is in flight.
// Reset clears the row counter, the colour counts, all queues and the
// registers (stop row returns to 1024); no sweep is needed afterwards.
// If the receiver stops popping, two results are held; the next frame end
// then stops the back part, the eight-entry inner queue fills and full rises.
`default_nettype none

module hsv_colour_defect_classifier_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [hcdc_pkg::PIX_W-1:0]      pix_blue,
    input  logic [hcdc_pkg::PIX_W-1:0]      pix_green,
    input  logic [hcdc_pkg::PIX_W-1:0]      pix_red,
    input  logic                            row_end,
    input  logic                            frame_end,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      defect_class,
    output logic [hcdc_pkg::TOTAL_W-1:0]    red_total,
    output logic [hcdc_pkg::TOTAL_W-1:0]    blue_total,
    input  logic                            cfg_we,
    input  logic [hcdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hcdc_pkg::*;

    logic [BOX_W-1:0]     red_box_a_reg;
    logic [BOX_W-1:0]     red_box_b_reg;
    logic [BOX_W-1:0]     blue_box_reg;
    logic [THR_W-1:0]     red_threshold_reg;
    logic [THR_W-1:0]     blue_threshold_reg;
    logic [CFG_ROW_W-1:0] first_row_reg;
    logic [CFG_ROW_W-1:0] stop_row_reg;
    front_cfg_t           front_cfg;
    logic                 flag_valid;
    pix_flags_t           flag_data;
    logic                 mq_valid;
    pix_flags_t           mq_head;
    logic                 mq_pop;
    result_t              res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_box_a_reg      <= '0;
            red_box_b_reg      <= '0;
            blue_box_reg       <= '0;
            red_threshold_reg  <= '0;
            blue_threshold_reg <= '0;
            first_row_reg      <= '0;
            stop_row_reg       <= STOP_ROW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RED_BOX_A:      red_box_a_reg      <= cfg_data[BOX_W-1:0];
                CFG_RED_BOX_B:      red_box_b_reg      <= cfg_data[BOX_W-1:0];
                CFG_BLUE_BOX:       blue_box_reg       <= cfg_data[BOX_W-1:0];
                CFG_RED_THRESHOLD:  red_threshold_reg  <= cfg_data[THR_W-1:0];
                CFG_BLUE_THRESHOLD: blue_threshold_reg <= cfg_data[THR_W-1:0];
                CFG_FIRST_ROW:      first_row_reg      <= cfg_data[CFG_ROW_W-1:0];
                CFG_STOP_ROW:       stop_row_reg       <= cfg_data[CFG_ROW_W-1:0];
                default:            ;
            endcase
        end
    end

    assign front_cfg.red_box_a = red_box_a_reg;
    assign front_cfg.red_box_b = red_box_b_reg;
    assign front_cfg.blue_box  = blue_box_reg;
    assign front_cfg.first_row = first_row_reg;
    assign front_cfg.stop_row  = stop_row_reg;

    // Pixel classification.
    hcdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pix_blue   (pix_blue),
        .pix_green  (pix_green),
        .pix_red    (pix_red),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .cfg        (front_cfg),
        .slot_free  (mq_pop),
        .flag_valid (flag_valid),
        .flag_data  (flag_data)
    );

    // Decoupling queue.
    hcdc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (flag_valid),
        .push_data (flag_data),
        .pop       (mq_pop),
        .has_data  (mq_valid),
        .head      (mq_head)
    );

    // Counting and frame results.
    hcdc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mq_valid       (mq_valid),
        .mq_head        (mq_head),
        .mq_pop         (mq_pop),
        .red_threshold  (red_threshold_reg),
        .blue_threshold (blue_threshold_reg),
        .empty          (empty),
        .pop            (pop),
        .res            (res)
    );

    assign defect_class = res.cls;
    assign red_total    = res.red_total;
    assign blue_total   = res.blue_total;

endmodule

`default_nettype wire

[hw/rtl/hcdc_front.sv]
// Front part: row window, pipelined BGR to HSV conversion and colour box tests.
`default_nettype none

module hcdc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [hcdc_pkg::PIX_W-1:0] pix_blue,
    input  logic [hcdc_pkg::PIX_W-1:0] pix_green,
    input  logic [hcdc_pkg::PIX_W-1:0] pix_red,
    input  logic                       row_end,
    input  logic                       frame_end,
    input  hcdc_pkg::front_cfg_t       cfg,
    input  logic                       slot_free,
    output logic                       flag_valid,
    output hcdc_pkg::pix_flags_t       flag_data
);
    import hcdc_pkg::*;

    logic                 accept;
    logic [ROW_W-1:0]     row_index_reg;
    logic [ROW_W-1:0]     row_index_next;
    logic                 in_window;
    logic [MQ_CNT_W-1:0]  credit_reg;
    logic [MQ_CNT_W-1:0]  credit_next;

    // Stage 0: captured pixel.
    logic                 s0_valid_reg;
    logic [PIX_W-1:0]     s0_blue_reg;
    logic [PIX_W-1:0]     s0_green_reg;
    logic [PIX_W-1:0]     s0_red_reg;
    logic                 s0_win_reg;
    logic                 s0_fend_reg;

    // Stage 1: value, chroma and hue numerator.
    logic [PIX_W-1:0]     v_max;
    logic [PIX_W-1:0]     v_min;
    logic [PIX_W-1:0]     v_diff;
    logic signed [11:0]   b_s;
    logic signed [11:0]   g_s;
    logic signed [11:0]   r_s;
    logic signed [11:0]   d_s;
    logic signed [11:0]   raw;
    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     s1_v_reg;
    logic [PIX_W-1:0]     s1_diff_reg;
    logic signed [11:0]   s1_raw_reg;
    logic                 s1_win_reg;
    logic                 s1_fend_reg;

    // Stage 2: reciprocals.
    logic [RECIP_S_W-1:0] recip_s_tab [TAB_DEPTH];
    logic [RECIP_H_W-1:0] recip_h_tab [TAB_DEPTH];
    logic                 s2_valid_reg;
    logic [PIX_W-1:0]     s2_v_reg;
    logic [PIX_W-1:0]     s2_diff_reg;
    logic signed [11:0]   s2_raw_reg;
    logic [RECIP_S_W-1:0] s2_rs_reg;
    logic [RECIP_H_W-1:0] s2_rh_reg;
    logic                 s2_win_reg;
    logic                 s2_fend_reg;

    // Stage 3: products.
    logic [27:0]          s_prod;
    logic signed [29:0]   h_prod;
    logic                 s3_valid_reg;
    logic [PIX_W-1:0]     s3_v_reg;
    logic [27:0]          s3_sprod_reg;
    logic signed [29:0]   s3_hprod_reg;
    logic                 s3_win_reg;
    logic                 s3_fend_reg;

    // Output stage: rounding, hue wrap and box tests.
    logic [28:0]          s_sum;
    logic signed [30:0]   h_sum;
    logic signed [30:0]   h_q;
    logic [9:0]           h_wrap;
    logic [PIX_W-1:0]     h_val;
    logic [PIX_W-1:0]     s_val;
    logic                 red_match;
    logic                 blue_match;

    // Inclusive test of H, S and V against one packed box.
    function automatic logic box_hit(input logic [BOX_W-1:0] box,
                                     input logic [PIX_W-1:0] h,
                                     input logic [PIX_W-1:0] s,
                                     input logic [PIX_W-1:0] v);
        box_hit = (h >= box[7:0])   && (h <= box[31:24]) &&
                  (s >= box[15:8])  && (s <= box[39:32]) &&
                  (v >= box[23:16]) && (v <= box[47:40]);
    endfunction

    // A slot is reserved in the queue for every pixel in flight, so the
    // pipeline never has to stall.
    assign accept = push && !full;
    assign full   = (credit_reg == MQ_CNT_W'(MQ_DEPTH));

    always_comb
    begin
        credit_next = credit_reg + MQ_CNT_W'(accept) - MQ_CNT_W'(slot_free);
    end

    // Row counting within the frame; the count holds at the row limit.
    assign in_window = (WIN_W'(row_index_reg) >= WIN_W'(cfg.first_row)) &&
                       (WIN_W'(row_index_reg) <  WIN_W'(cfg.stop_row));

    always_comb
    begin
        row_index_next = row_index_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                row_index_next = '0;
            end
            else if (row_end && (row_index_reg < ROW_W'(MAX_ROWS)))
            begin
                row_index_next = row_index_reg + 1'b1;
            end
        end
    end

    // Maximum, minimum and the hue numerator for the dominant channel.
    always_comb
    begin
        v_max = s0_blue_reg;
        v_min = s0_blue_reg;
        if (s0_green_reg > v_max)
        begin
            v_max = s0_green_reg;
        end
        if (s0_red_reg > v_max)
        begin
            v_max = s0_red_reg;
        end
        if (s0_green_reg < v_min)
        begin
            v_min = s0_green_reg;
        end
        if (s0_red_reg < v_min)
        begin
            v_min = s0_red_reg;
        end
        v_diff = v_max - v_min;
        b_s = $signed({4'b0000, s0_blue_reg});
        g_s = $signed({4'b0000, s0_green_reg});
        r_s = $signed({4'b0000, s0_red_reg});
        d_s = $signed({4'b0000, v_diff});
        priority if (v_max == s0_red_reg)
        begin
            raw = g_s - b_s;
        end
        else if (v_max == s0_green_reg)
        begin
            raw = b_s - r_s + (d_s <<< 1);
        end
        else
        begin
            raw = r_s - g_s + (d_s <<< 2);
        end
    end

    // Rounded reciprocal tables, ties to even, worked out at elaboration.
    assign recip_s_tab[0] = '0;
    assign recip_h_tab[0] = '0;

    for (genvar gi = 1; gi < TAB_DEPTH; gi++)
    begin : g_recip
        localparam int QS = S_NUM / gi;
        localparam int RS = S_NUM % gi;
        localparam int VS = QS + (((2 * RS > gi) || ((2 * RS == gi) && (QS % 2 == 1)))
                                  ? 1 : 0);
        localparam int DH = 6 * gi;
        localparam int QH = H_NUM / DH;
        localparam int RH = H_NUM % DH;
        localparam int VH = QH + (((2 * RH > DH) || ((2 * RH == DH) && (QH % 2 == 1)))
                                  ? 1 : 0);
        assign recip_s_tab[gi] = RECIP_S_W'(VS);
        assign recip_h_tab[gi] = RECIP_H_W'(VH);
    end

    // Saturation and hue products.
    always_comb
    begin
        s_prod = s2_diff_reg * s2_rs_reg;
        h_prod = s2_raw_reg * $signed({1'b0, s2_rh_reg});
    end

    // Rounding to 8 bits; a negative hue wraps by a full turn of 180.
    always_comb
    begin
        s_sum  = {1'b0, s3_sprod_reg} + 29'd2048;
        s_val  = s_sum[19:12];
        h_sum  = $signed({s3_hprod_reg[29], s3_hprod_reg}) + 31'sd2048;
        h_q    = h_sum >>> 12;
        h_wrap = {h_q[8], h_q[8:0]} + 10'd180;
        h_val  = h_q[8] ? h_wrap[7:0] : h_q[7:0];
        red_match  = box_hit(cfg.red_box_a, h_val, s_val, s3_v_reg) ||
                     box_hit(cfg.red_box_b, h_val, s_val, s3_v_reg);
        blue_match = box_hit(cfg.blue_box, h_val, s_val, s3_v_reg);
    end

    assign flag_valid          = s3_valid_reg;
    assign flag_data.red_hit   = s3_win_reg && red_match;
    assign flag_data.blue_hit  = s3_win_reg && blue_match;
    assign flag_data.frame_end = s3_fend_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg <= '0;
            credit_reg    <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            row_index_reg <= row_index_next;
            credit_reg    <= credit_next;
            s0_valid_reg  <= accept;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s0_blue_reg  <= pix_blue;
        s0_green_reg <= pix_green;
        s0_red_reg   <= pix_red;
        s0_win_reg   <= in_window;
        s0_fend_reg  <= frame_end;

        s1_v_reg     <= v_max;
        s1_diff_reg  <= v_diff;
        s1_raw_reg   <= raw;
        s1_win_reg   <= s0_win_reg;
        s1_fend_reg  <= s0_fend_reg;

        s2_v_reg     <= s1_v_reg;
        s2_diff_reg  <= s1_diff_reg;
        s2_raw_reg   <= s1_raw_reg;
        s2_rs_reg    <= recip_s_tab[s1_v_reg];
        s2_rh_reg    <= recip_h_tab[s1_diff_reg];
        s2_win_reg   <= s1_win_reg;
        s2_fend_reg  <= s1_fend_reg;

        s3_v_reg     <= s2_v_reg;
        s3_sprod_reg <= s_prod;
        s3_hprod_reg <= h_prod;
        s3_win_reg   <= s2_win_reg;
        s3_fend_reg  <= s2_fend_reg;
    end

`ifndef ASSERT_OFF
    // Reserved slots never exceed the queue depth.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= MQ_CNT_W'(MQ_DEPTH))
        else $error("front: more pixels reserved than queue slots");
`endif

endmodule

`default_nettype wire

[hw/rtl/hcdc_fifo.sv]
// Short queue of per-pixel outcomes between the front and back parts.
`default_nettype none

module hcdc_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hcdc_pkg::pix_flags_t push_data,
    input  logic                 pop,
    output logic                 has_data,
    output hcdc_pkg::pix_flags_t head
);
    import hcdc_pkg::*;

    pix_flags_t          mem_reg [MQ_DEPTH];
    logic [MQ_PTR_W-1:0] wr_ptr_reg;
    logic [MQ_PTR_W-1:0] wr_ptr_next;
    logic [MQ_PTR_W-1:0] rd_ptr_reg;
    logic [MQ_PTR_W-1:0] rd_ptr_next;
    logic [MQ_CNT_W-1:0] cnt_reg;
    logic [MQ_CNT_W-1:0] cnt_next;

    assign has_data = (cnt_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + MQ_CNT_W'(push) - MQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    // The reservation scheme upstream must keep a free slot for every beat.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < MQ_CNT_W'(MQ_DEPTH)) || pop)
        else $error("fifo: write into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("fifo: read from an empty queue");
`endif

endmodule

`default_nettype wire

[hw/rtl/hcdc_back.sv]
// Back part: saturating colour counters, frame classification and result queue.
`default_nettype none

module hcdc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       mq_valid,
    input  hcdc_pkg::pix_flags_t       mq_head,
    output logic                       mq_pop,
    input  logic [hcdc_pkg::THR_W-1:0] red_threshold,
    input  logic [hcdc_pkg::THR_W-1:0] blue_threshold,
    output logic                       empty,
    input  logic                       pop,
    output hcdc_pkg::result_t          res
);
    import hcdc_pkg::*;

    logic [COUNT_BITS-1:0] red_count_reg;
    logic [COUNT_BITS-1:0] red_count_next;
    logic [COUNT_BITS-1:0] blue_count_reg;
    logic [COUNT_BITS-1:0] blue_count_next;
    logic [COUNT_BITS-1:0] red_inc;
    logic [COUNT_BITS-1:0] blue_inc;
    defect_class_t         cls;
    result_t               res_new;
    logic                  res_full;
    logic                  res_push;
    logic                  res_pop;
    result_t               res_mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]  res_wr_reg;
    logic [RES_PTR_W-1:0]  res_wr_next;
    logic [RES_PTR_W-1:0]  res_rd_reg;
    logic [RES_PTR_W-1:0]  res_rd_next;
    logic [RES_CNT_W-1:0]  res_cnt_reg;
    logic [RES_CNT_W-1:0]  res_cnt_next;

    // A frame-end beat waits only if the result queue has no room.
    assign res_full = (res_cnt_reg == RES_CNT_W'(RES_DEPTH));
    assign empty    = (res_cnt_reg == '0);
    assign mq_pop   = mq_valid && (!mq_head.frame_end || !res_full);
    assign res_push = mq_pop && mq_head.frame_end;
    assign res_pop  = pop && !empty;
    assign res      = res_mem_reg[res_rd_reg];

    // Saturating counts including the current pixel, and the frame verdict.
    always_comb
    begin
        red_inc  = (mq_head.red_hit && !(&red_count_reg)) ?
                   red_count_reg + 1'b1 : red_count_reg;
        blue_inc = (mq_head.blue_hit && !(&blue_count_reg)) ?
                   blue_count_reg + 1'b1 : blue_count_reg;
        priority if (CMP_W'(red_inc) > CMP_W'(red_threshold))
        begin
            cls = CLASS_RED;
        end
        else if (CMP_W'(blue_inc) > CMP_W'(blue_threshold))
        begin
            cls = CLASS_BLUE;
        end
        else
        begin
            cls = CLASS_NONE;
        end
        res_new.cls        = cls;
        res_new.red_total  = TOTAL_W'(red_inc);
        res_new.blue_total = TOTAL_W'(blue_inc);
    end

    // Counters clear at the end of each frame.
    always_comb
    begin
        red_count_next  = red_count_reg;
        blue_count_next = blue_count_reg;
        if (mq_pop)
        begin
            if (mq_head.frame_end)
            begin
                red_count_next  = '0;
                blue_count_next = '0;
            end
            else
            begin
                red_count_next  = red_inc;
                blue_count_next = blue_inc;
            end
        end
    end

    // Result queue pointers.
    always_comb
    begin
        res_wr_next = res_wr_reg;
        res_rd_next = res_rd_reg;
        if (res_push)
        begin
            res_wr_next = (res_wr_reg == RES_PTR_W'(RES_DEPTH - 1)) ?
                          '0 : res_wr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rd_next = (res_rd_reg == RES_PTR_W'(RES_DEPTH - 1)) ?
                          '0 : res_rd_reg + 1'b1;
        end
        res_cnt_next = res_cnt_reg + RES_CNT_W'(res_push) - RES_CNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_count_reg  <= '0;
            blue_count_reg <= '0;
            res_wr_reg     <= '0;
            res_rd_reg     <= '0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            red_count_reg  <= red_count_next;
            blue_count_reg <= blue_count_next;
            res_wr_reg     <= res_wr_next;
            res_rd_reg     <= res_rd_next;
            res_cnt_reg    <= res_cnt_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_new;
        end
    end

`ifndef ASSERT_OFF
    // Both counts start from zero after a frame has been closed.
    a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (mq_pop && mq_head.frame_end) |=> (red_count_reg == '0) && (blue_count_reg == '0))
        else $error("back: counts not cleared after frame end");
`endif

endmodule

`default_nettype wire
